// File: design/pidaw_pkg.sv
package pidaw_pkg;

  localparam int DataW   = 32;
  localparam int StepW   = 31;
  localparam int CfgIdxW = 3;
  localparam int AccW    = 64;
  localparam int ProdW   = 62;
  localparam int DivNumW = 49;
  localparam int DivCntW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_TARGET_VALUE = 3'd3,
    REG_DRIVE_MIN    = 3'd4,
    REG_DRIVE_MAX    = 3'd5,
    REG_STEP_TIME    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [DataW-1:0] prop_gain;
    logic signed [DataW-1:0] integ_gain;
    logic signed [DataW-1:0] deriv_gain;
    logic signed [DataW-1:0] target_value;
    logic signed [DataW-1:0] drive_min;
    logic signed [DataW-1:0] drive_max;
    logic        [StepW-1:0] step_time;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_CAPTURE  = 4'd1,
    CMD_ERR      = 4'd2,
    CMD_MUL_OPS  = 4'd3,
    CMD_MUL_LO   = 4'd4,
    CMD_MUL_HI   = 4'd5,
    CMD_MUL_FIN  = 4'd6,
    CMD_MUL_USE  = 4'd7,
    CMD_DIV_LOAD = 4'd8,
    CMD_DIV_STEP = 4'd9,
    CMD_DIV_USE  = 4'd10,
    CMD_FINISH   = 4'd11
  } dp_op_t;

  typedef enum logic [1:0] {
    TERM_INC = 2'd0,
    TERM_P   = 2'd1,
    TERM_I   = 2'd2,
    TERM_D   = 2'd3
  } term_t;

  typedef enum logic {
    DIV_LIM = 1'b0,
    DIV_DER = 1'b1
  } div_kind_t;

  typedef struct packed {
    dp_op_t    op;
    term_t     term;
    div_kind_t div_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_item;
    logic ki_big;
    logic div_last;
  } dp_stat_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

endpackage

// File: design/pidaw_in_if.sv
interface pidaw_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [pidaw_pkg::DataW-1:0]  measured_value;

  modport source (output valid, opcode, measured_value, input ready);
  modport sink   (input valid, opcode, measured_value, output ready);
endinterface

// File: design/pidaw_out_if.sv
interface pidaw_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidaw_pkg::DataW-1:0]  drive_value;
  logic                                drive_limited;

  modport source (output valid, drive_value, drive_limited, input ready);
  modport sink   (input valid, drive_value, drive_limited, output ready);
endinterface

// File: design/pidaw_cfg_if.sv
interface pidaw_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pidaw_pkg::CfgIdxW-1:0]       index;
  logic [pidaw_pkg::DataW-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/pid_controller_antiwindup.sv
// PID controller with integral clamp anti-windup, Q16.16 fixed point. Each item on the
// sample channel is a compute command with a measurement or a clear command, and yields
// exactly one transfer on the result channel. One item is worked on at a time: a compute
// command puts the derivative, and the integral limit too when the integral gain
// magnitude is above 0.0001, through the shared restoring divider at one quotient bit
// per cycle, and forms its four Q16.16 products on the single shared 32x32 multiplier.
// A finished result waits in the output register while the next item is accepted.
// Configuration writes are always ready and must only be issued while no item is in
// flight.
module pid_controller_antiwindup (
  input  logic          clk,
  input  logic          rst,
  pidaw_in_if.sink      sample,
  pidaw_out_if.source   result,
  pidaw_cfg_if.sink     cfg
);

  pidaw_pkg::cfg_t       regs;
  pidaw_pkg::dp_cmd_t    cmd;
  pidaw_pkg::dp_stat_t   stat;
  logic                  in_ready;
  logic                  out_valid;

  pidaw_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wr   (cfg),
    .regs (regs)
  );

  pidaw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (in_ready),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  pidaw_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (regs),
    .cmd            (cmd),
    .opcode         (sample.opcode),
    .measured_value (sample.measured_value),
    .stat           (stat),
    .drive_value    (result.drive_value),
    .drive_limited  (result.drive_limited)
  );

  assign sample.ready = in_ready;
  assign result.valid = out_valid;

endmodule

// File: design/pidaw_cfg.sv
module pidaw_cfg (
  input  logic               clk,
  input  logic               rst,
  pidaw_cfg_if.sink          wr,
  output pidaw_pkg::cfg_t    regs
);

  assign wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain    <= '0;
      regs.integ_gain   <= '0;
      regs.deriv_gain   <= '0;
      regs.target_value <= '0;
      regs.drive_min    <= 32'sh8000_0000;
      regs.drive_max    <= 32'sh7FFF_FFFF;
      regs.step_time    <= 31'd65536;
    end else if (wr.valid && wr.ready) begin
      unique case (wr.index)
        pidaw_pkg::REG_PROP_GAIN:    regs.prop_gain    <= $signed(wr.data);
        pidaw_pkg::REG_INTEG_GAIN:   regs.integ_gain   <= $signed(wr.data);
        pidaw_pkg::REG_DERIV_GAIN:   regs.deriv_gain   <= $signed(wr.data);
        pidaw_pkg::REG_TARGET_VALUE: regs.target_value <= $signed(wr.data);
        pidaw_pkg::REG_DRIVE_MIN:    regs.drive_min    <= $signed(wr.data);
        pidaw_pkg::REG_DRIVE_MAX:    regs.drive_max    <= $signed(wr.data);
        pidaw_pkg::REG_STEP_TIME:    regs.step_time    <= wr.data[pidaw_pkg::StepW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: design/pidaw_dp.sv
module pidaw_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  pidaw_pkg::cfg_t                     cfg,
  input  pidaw_pkg::dp_cmd_t                  cmd,
  input  logic                                opcode,
  input  logic signed [pidaw_pkg::DataW-1:0]  measured_value,
  output pidaw_pkg::dp_stat_t                 stat,
  output logic signed [pidaw_pkg::DataW-1:0]  drive_value,
  output logic                                drive_limited
);

  localparam logic [pidaw_pkg::ProdW-1:0]   TermCap   = {1'b1, 61'b0};
  localparam logic [63:0]                   PhiCapMin = 64'h0000_2000_0000_0000;
  localparam logic signed [64:0]            SatHi     = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0]            SatLo     = -65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0]                   KiMinMag  = 32'd7;
  localparam logic [pidaw_pkg::DivCntW-1:0] DivLast   = pidaw_pkg::DivCntW'(pidaw_pkg::DivNumW - 1);

  logic                                 clear_item;
  logic signed [31:0]                   meas;
  logic signed [31:0]                   err;
  logic signed [31:0]                   last_error;
  logic signed [63:0]                   integral_sum;
  logic signed [63:0]                   acc;
  logic [pidaw_pkg::DivNumW-1:0]        deriv_mag;
  logic                                 deriv_neg;
  logic [31:0]                          a_mag;
  logic [63:0]                          b_mag;
  logic                                 neg;
  logic [63:0]                          plo;
  logic [63:0]                          phi;
  logic [pidaw_pkg::ProdW-1:0]          pmag;
  logic                                 pneg;
  logic [pidaw_pkg::DivNumW-1:0]        dnum;
  logic [31:0]                          drem;
  logic [31:0]                          dden;
  logic [pidaw_pkg::DivCntW-1:0]        dcnt;
  logic                                 dsign;

  logic [31:0]                          dt;
  logic signed [32:0]                   err_diff;
  logic signed [31:0]                   err_sat;
  logic [31:0]                          mul_b;
  logic [63:0]                          mul_p;
  logic [pidaw_pkg::ProdW-1:0]          m_sum;
  logic [pidaw_pkg::ProdW-1:0]          m_fin;
  logic signed [63:0]                   term_s;
  logic signed [64:0]                   integ_add;
  logic signed [63:0]                   integ_sat;
  logic signed [63:0]                   lim_s;
  logic signed [63:0]                   integ_clamp;
  logic signed [32:0]                   der_diff;
  logic [32:0]                          der_mag;
  logic [32:0]                          trial;
  logic                                 trial_ge;
  logic [31:0]                          rem_next;
  logic [31:0]                          op_a;
  logic [63:0]                          op_b;
  logic                                 op_neg;
  logic signed [63:0]                   out_sum;
  logic                                 out_lim;

  assign dt = (cfg.step_time == '0) ? 32'd1 : {1'b0, cfg.step_time};

  // error, saturated to 32 bits
  assign err_diff = {cfg.target_value[31], cfg.target_value} - {meas[31], meas};
  assign err_sat  = (err_diff[32] != err_diff[31]) ?
                    (err_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : err_diff[31:0];

  // shared 32x32 multiplier: low half then high half of the wide operand
  assign mul_b = (cmd.op == pidaw_pkg::CMD_MUL_HI) ? b_mag[63:32] : b_mag[31:0];
  assign mul_p = {32'b0, a_mag} * {32'b0, mul_b};

  assign m_sum = {1'b0, phi[44:0], 16'b0} + {14'b0, plo[63:16]};
  assign m_fin = (phi >= PhiCapMin || m_sum > TermCap) ? TermCap : m_sum;

  assign term_s    = pneg ? -$signed({2'b0, pmag}) : $signed({2'b0, pmag});
  assign integ_add = {integral_sum[63], integral_sum} + {term_s[63], term_s};

  always_comb begin
    if (integ_add > SatHi) begin
      integ_sat = SatHi[63:0];
    end else if (integ_add < SatLo) begin
      integ_sat = SatLo[63:0];
    end else begin
      integ_sat = integ_add[63:0];
    end
  end

  assign lim_s = $signed({15'b0, dnum});

  always_comb begin
    integ_clamp = integral_sum;
    if (integral_sum > lim_s) begin
      integ_clamp = lim_s;
    end else if (integral_sum < -lim_s) begin
      integ_clamp = -lim_s;
    end
  end

  assign der_diff = {err[31], err} - {last_error[31], last_error};
  assign der_mag  = pidaw_pkg::mag33(der_diff);

  // restoring division, one quotient bit per cycle
  assign trial    = {drem, dnum[pidaw_pkg::DivNumW-1]};
  assign trial_ge = trial >= {1'b0, dden};
  assign rem_next = trial_ge ? 32'(trial - {1'b0, dden}) : trial[31:0];

  always_comb begin
    case (cmd.term)
      pidaw_pkg::TERM_INC: begin
        op_a   = pidaw_pkg::mag32(err);
        op_b   = {32'b0, dt};
        op_neg = err[31];
      end
      pidaw_pkg::TERM_P: begin
        op_a   = pidaw_pkg::mag32(cfg.prop_gain);
        op_b   = {32'b0, pidaw_pkg::mag32(err)};
        op_neg = cfg.prop_gain[31] ^ err[31];
      end
      pidaw_pkg::TERM_I: begin
        op_a   = pidaw_pkg::mag32(cfg.integ_gain);
        op_b   = pidaw_pkg::mag64(integral_sum);
        op_neg = cfg.integ_gain[31] ^ integral_sum[63];
      end
      default: begin
        op_a   = pidaw_pkg::mag32(cfg.deriv_gain);
        op_b   = {15'b0, deriv_mag};
        op_neg = cfg.deriv_gain[31] ^ deriv_neg;
      end
    endcase
  end

  // output clamp: max first, then min
  always_comb begin
    out_sum = acc;
    out_lim = 1'b0;
    if (out_sum > 64'(cfg.drive_max)) begin
      out_sum = 64'(cfg.drive_max);
      out_lim = 1'b1;
    end
    if (out_sum < 64'(cfg.drive_min)) begin
      out_sum = 64'(cfg.drive_min);
      out_lim = 1'b1;
    end
  end

  assign stat.clear_item = clear_item;
  assign stat.ki_big     = pidaw_pkg::mag32(cfg.integ_gain) >= KiMinMag;
  assign stat.div_last   = dcnt == DivLast;

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
    end else begin
      unique case (cmd.op)
        pidaw_pkg::CMD_MUL_USE: begin
          if (cmd.term == pidaw_pkg::TERM_INC) begin
            integral_sum <= integ_sat;
          end
        end
        pidaw_pkg::CMD_DIV_USE: begin
          if (cmd.div_kind == pidaw_pkg::DIV_LIM) begin
            integral_sum <= integ_clamp;
          end
        end
        pidaw_pkg::CMD_FINISH: begin
          if (clear_item) begin
            integral_sum <= '0;
            last_error   <= '0;
          end else begin
            last_error <= err;
          end
        end
        pidaw_pkg::CMD_NONE, pidaw_pkg::CMD_CAPTURE, pidaw_pkg::CMD_ERR,
        pidaw_pkg::CMD_MUL_OPS, pidaw_pkg::CMD_MUL_LO, pidaw_pkg::CMD_MUL_HI,
        pidaw_pkg::CMD_MUL_FIN, pidaw_pkg::CMD_DIV_LOAD, pidaw_pkg::CMD_DIV_STEP: ;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pidaw_pkg::CMD_CAPTURE: begin
        clear_item <= opcode;
        meas       <= measured_value;
      end
      pidaw_pkg::CMD_ERR: begin
        err <= err_sat;
        acc <= '0;
      end
      pidaw_pkg::CMD_MUL_OPS: begin
        a_mag <= op_a;
        b_mag <= op_b;
        neg   <= op_neg;
      end
      pidaw_pkg::CMD_MUL_LO: plo <= mul_p;
      pidaw_pkg::CMD_MUL_HI: phi <= mul_p;
      pidaw_pkg::CMD_MUL_FIN: begin
        pmag <= m_fin;
        pneg <= neg;
      end
      pidaw_pkg::CMD_MUL_USE: begin
        if (cmd.term != pidaw_pkg::TERM_INC) begin
          acc <= acc + term_s;
        end
      end
      pidaw_pkg::CMD_DIV_LOAD: begin
        drem <= '0;
        dcnt <= '0;
        if (cmd.div_kind == pidaw_pkg::DIV_LIM) begin
          dnum  <= {1'b0, pidaw_pkg::mag32(cfg.drive_max), 16'b0};
          dden  <= pidaw_pkg::mag32(cfg.integ_gain);
          dsign <= 1'b0;
        end else begin
          dnum  <= {der_mag, 16'b0};
          dden  <= dt;
          dsign <= der_diff[32];
        end
      end
      pidaw_pkg::CMD_DIV_STEP: begin
        drem <= rem_next;
        dnum <= {dnum[pidaw_pkg::DivNumW-2:0], trial_ge};
        dcnt <= dcnt + 1'b1;
      end
      pidaw_pkg::CMD_DIV_USE: begin
        if (cmd.div_kind == pidaw_pkg::DIV_DER) begin
          deriv_mag <= dnum;
          deriv_neg <= dsign;
        end
      end
      pidaw_pkg::CMD_FINISH: begin
        if (clear_item) begin
          drive_value   <= '0;
          drive_limited <= 1'b0;
        end else begin
          drive_value   <= out_sum[31:0];
          drive_limited <= out_lim;
        end
      end
      pidaw_pkg::CMD_NONE: ;
      default: ;
    endcase
  end

endmodule

// File: design/pidaw_ctrl.sv
module pidaw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  pidaw_pkg::dp_stat_t  stat,
  output pidaw_pkg::dp_cmd_t   cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_LOAD     = 11'b000_0000_0010,
    S_MUL_OPS  = 11'b000_0000_0100,
    S_MUL_LO   = 11'b000_0000_1000,
    S_MUL_HI   = 11'b000_0001_0000,
    S_MUL_FIN  = 11'b000_0010_0000,
    S_MUL_USE  = 11'b000_0100_0000,
    S_DIV_LOAD = 11'b000_1000_0000,
    S_DIV_RUN  = 11'b001_0000_0000,
    S_DIV_USE  = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t                state;
  state_t                state_next;
  pidaw_pkg::term_t      term;
  pidaw_pkg::term_t      term_next;
  pidaw_pkg::div_kind_t  div_kind;
  pidaw_pkg::div_kind_t  div_kind_next;
  logic                  out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    term_next     = term;
    div_kind_next = div_kind;
    cmd.op        = pidaw_pkg::CMD_NONE;
    cmd.term      = term;
    cmd.div_kind  = div_kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = pidaw_pkg::CMD_CAPTURE;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.clear_item) begin
          state_next = S_FINISH;
        end else begin
          cmd.op     = pidaw_pkg::CMD_ERR;
          term_next  = pidaw_pkg::TERM_INC;
          state_next = S_MUL_OPS;
        end
      end
      S_MUL_OPS: begin
        cmd.op     = pidaw_pkg::CMD_MUL_OPS;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op     = pidaw_pkg::CMD_MUL_LO;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op     = pidaw_pkg::CMD_MUL_HI;
        state_next = S_MUL_FIN;
      end
      S_MUL_FIN: begin
        cmd.op     = pidaw_pkg::CMD_MUL_FIN;
        state_next = S_MUL_USE;
      end
      S_MUL_USE: begin
        cmd.op = pidaw_pkg::CMD_MUL_USE;
        case (term)
          pidaw_pkg::TERM_INC: begin
            // skip the clamp limit when the integral gain is negligible
            div_kind_next = stat.ki_big ? pidaw_pkg::DIV_LIM : pidaw_pkg::DIV_DER;
            state_next    = S_DIV_LOAD;
          end
          pidaw_pkg::TERM_P: begin
            term_next  = pidaw_pkg::TERM_I;
            state_next = S_MUL_OPS;
          end
          pidaw_pkg::TERM_I: begin
            term_next  = pidaw_pkg::TERM_D;
            state_next = S_MUL_OPS;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_DIV_LOAD: begin
        cmd.op     = pidaw_pkg::CMD_DIV_LOAD;
        state_next = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.op = pidaw_pkg::CMD_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_DIV_USE;
        end
      end
      S_DIV_USE: begin
        cmd.op = pidaw_pkg::CMD_DIV_USE;
        if (div_kind == pidaw_pkg::DIV_LIM) begin
          div_kind_next = pidaw_pkg::DIV_DER;
          state_next    = S_DIV_LOAD;
        end else begin
          term_next  = pidaw_pkg::TERM_P;
          state_next = S_MUL_OPS;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.op     = pidaw_pkg::CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      term      <= pidaw_pkg::TERM_INC;
      div_kind  <= pidaw_pkg::DIV_LIM;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      term     <= term_next;
      div_kind <= div_kind_next;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
